>>> rtl/bfsp_pkg.sv
// shared types, constants and codes for the shortest path block
// no dependencies; bfsp_ctrl, bfsp_datapath and the top level import this package
`timescale 1ns / 1ps

package bfsp_pkg;

   // field widths fixed by the interface
   localparam int NODE_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int WEIGHT_W   = 16;
   localparam int DIST_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int NODE_LIMIT = 2 ** NODE_W;

   // default sizing
   localparam int MAX_NODES_DEF = 16;

   // largest distance, reported for unreachable vertices
   localparam logic signed [DIST_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEG_CYCLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SRC   = 2'd2;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COUNT_W;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_NODE = 1'd1;
   localparam logic [COUNT_W-1:0]   NODE_COUNT_RST  = 5'd16;
   localparam logic [NODE_W-1:0]    SOURCE_NODE_RST = 4'd0;

   // one edge entry transaction
   typedef struct packed {
      logic [NODE_W-1:0]          row_index;
      logic [NODE_W-1:0]          column_index;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic                       last_entry;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [NODE_W-1:0]        vertex;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic [STATUS_W-1:0]      status;
      logic                     last_result;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic                store;
      logic                init;
      logic                load_row;
      logic                issue;
      logic                check;
      logic                emit;
      logic                emit_status;
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   row;
      logic [NODE_W-1:0]   col;
      logic [NODE_W-1:0]   vertex;
      logic                last_result;
      logic [NODE_W-1:0]   source;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic found;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/bfsp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bfsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfsp_ctrl.sv
// sequencer: configuration registers, pass/row/column counters, run control
// depends on bfsp_pkg
`timescale 1ns / 1ps

module bfsp_ctrl #(
   parameter int MAX_NODES = bfsp_pkg::MAX_NODES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_last,
   input  logic                                csr_wr_en,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfsp_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  bfsp_pkg::stat_type                  stat,
   output bfsp_pkg::cmd_type                   cmd
);
   import bfsp_pkg::*;

   localparam int LIMIT_NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam int IDX_W       = $clog2(LIMIT_NODES);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_INIT   = 8'b0000_0010,
      S_ROW    = 8'b0000_0100,
      S_COL    = 8'b0000_1000,
      S_GAP    = 8'b0001_0000,
      S_DECIDE = 8'b0010_0000,
      S_EMIT   = 8'b0100_0000,
      S_STATUS = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    v_ff, v_in;
   logic [COUNT_W-1:0]  pass_ff, pass_in;
   logic                check_ff, check_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  node_count_ff;
   logic [NODE_W-1:0]   source_ff;

   logic [COUNT_W-1:0]  n_eff;
   logic [COUNT_W-1:0]  n_last;
   logic                src_ok;
   logic                i_last, j_last, v_last;

   // effective vertex count and range checks
   assign n_eff  = (node_count_ff > COUNT_W'(LIMIT_NODES)) ? COUNT_W'(LIMIT_NODES)
                                                           : node_count_ff;
   assign n_last = n_eff - COUNT_W'(1);
   assign src_ok = COUNT_W'(source_ff) < n_eff;
   assign i_last = COUNT_W'(i_ff) == n_last;
   assign j_last = COUNT_W'(j_ff) == n_last;
   assign v_last = COUNT_W'(v_ff) == n_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         source_ff     <= SOURCE_NODE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_NODE_COUNT:  node_count_ff <= csr_wr_data;
            REG_SOURCE_NODE: source_ff     <= csr_wr_data[NODE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      v_in      = v_ff;
      pass_in   = pass_ff;
      check_in  = check_ff;
      status_in = status_ff;
      req_ready = 1'b0;

      cmd             = '0;
      cmd.check       = check_ff;
      cmd.row         = NODE_W'(i_ff);
      cmd.col         = NODE_W'(j_ff);
      cmd.vertex      = NODE_W'(v_ff);
      cmd.last_result = v_last;
      cmd.status      = status_ff;
      cmd.source      = source_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  if (src_ok) begin
                     state_in = S_INIT;
                  end else begin
                     status_in = STATUS_BAD_SRC;
                     state_in  = S_STATUS;
                  end
               end
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            i_in     = '0;
            pass_in  = '0;
            check_in = (n_last == '0);
            state_in = S_ROW;
         end
         // latch the row distance and fetch the first column
         S_ROW: begin
            cmd.load_row = 1'b1;
            cmd.issue    = 1'b1;
            cmd.col      = '0;
            j_in         = IDX_W'(1);
            state_in     = (n_last == '0) ? S_GAP : S_COL;
         end
         S_COL: begin
            cmd.issue = 1'b1;
            j_in      = j_ff + IDX_W'(1);
            if (j_last) begin
               state_in = S_GAP;
            end
         end
         // last column of the row retires here
         S_GAP: begin
            if (i_last) begin
               i_in = '0;
               if (check_ff) begin
                  state_in = S_DECIDE;
               end else begin
                  if (pass_ff + COUNT_W'(1) == n_last) begin
                     check_in = 1'b1;
                  end
                  pass_in  = pass_ff + COUNT_W'(1);
                  state_in = S_ROW;
               end
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_ROW;
            end
         end
         S_DECIDE: begin
            v_in = '0;
            if (stat.found) begin
               status_in = STATUS_NEG_CYCLE;
               state_in  = S_STATUS;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               v_in     = v_ff + IDX_W'(1);
               if (v_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      v_ff      <= v_in;
      pass_ff   <= pass_in;
      check_ff  <= check_in;
      status_ff <= status_in;
   end

   // a result is only produced into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_status) |-> stat.out_free)
      else $error("result produced while output register busy");

   // no new entry is taken while a run is in progress
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("entry accepted during a run");

endmodule

>>> rtl/bfsp_datapath.sv
// datapath: weight matrix memory, distance table, relaxation stage, output register
// depends on bfsp_pkg and bfsp_ram
`timescale 1ns / 1ps

module bfsp_datapath #(
   parameter int MAX_NODES = bfsp_pkg::MAX_NODES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  bfsp_pkg::cmd_type   cmd,
   input  bfsp_pkg::req_type   req_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output bfsp_pkg::rsp_type   rsp_data,
   output bfsp_pkg::stat_type  stat
);
   import bfsp_pkg::*;

   localparam int LIMIT_NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam int IDX_W       = $clog2(LIMIT_NODES);
   localparam int RAM_DEPTH   = MAX_NODES * MAX_NODES;
   localparam int ADDR_W      = $clog2(RAM_DEPTH);

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [WEIGHT_W-1:0]      ram_rdata;

   logic signed [DIST_W-1:0] dist_ff [LIMIT_NODES];
   logic [LIMIT_NODES-1:0]   reach_ff;
   logic signed [DIST_W-1:0] cur_dist_ff;
   logic                     cur_reach_ff;
   logic [IDX_W-1:0]         row_ff;
   logic                     s1_valid_ff;
   logic                     s1_check_ff;
   logic [IDX_W-1:0]         s1_col_ff;
   logic                     found_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [IDX_W-1:0]         rd_idx;
   logic signed [DIST_W-1:0] tbl_dist;
   logic                     tbl_reach;
   logic signed [WEIGHT_W-1:0] s1_weight;
   logic signed [DIST_W-1:0] sum;
   logic                     relax;
   logic [IDX_W-1:0]         src_idx;

   // matrix storage, entries outside the matrix are dropped
   assign wr_en   = cmd.store && (int'(req_data.row_index) < MAX_NODES)
                              && (int'(req_data.column_index) < MAX_NODES);
   assign wr_addr = ADDR_W'(int'(req_data.row_index) * MAX_NODES
                            + int'(req_data.column_index));
   assign rd_addr = ADDR_W'(int'(cmd.row[IDX_W-1:0]) * MAX_NODES
                            + int'(cmd.col[IDX_W-1:0]));

   bfsp_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (RAM_DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.edge_weight),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // single table read port shared by row load, relaxation and output
   always_comb begin
      if (cmd.load_row) begin
         rd_idx = cmd.row[IDX_W-1:0];
      end else if (cmd.emit) begin
         rd_idx = cmd.vertex[IDX_W-1:0];
      end else begin
         rd_idx = s1_col_ff;
      end
   end

   assign tbl_dist  = dist_ff[rd_idx];
   assign tbl_reach = reach_ff[rd_idx];
   assign src_idx   = cmd.source[IDX_W-1:0];

   // relaxation of one edge entry
   assign s1_weight = ram_rdata;
   assign sum       = cur_dist_ff + DIST_W'(s1_weight);
   assign relax     = s1_valid_ff && (s1_weight != '0) && cur_reach_ff
                      && (!tbl_reach || (sum < tbl_dist));

   // pipeline control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_check_ff <= cmd.check;
      s1_col_ff   <= cmd.col[IDX_W-1:0];
   end

   // negative cycle flag
   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         found_ff <= 1'b0;
      end else if (relax && s1_check_ff) begin
         found_ff <= 1'b1;
      end
   end

   // reachable bits, cleared by reset and at run start
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= '0;
      end else if (cmd.init) begin
         reach_ff <= LIMIT_NODES'(1) << src_idx;
      end else if (relax && !s1_check_ff) begin
         reach_ff[s1_col_ff] <= 1'b1;
      end
   end

   // distances and current row copy, self loop updates the copy too
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         dist_ff[src_idx] <= '0;
      end else if (relax && !s1_check_ff) begin
         dist_ff[s1_col_ff] <= sum;
      end
      if (cmd.load_row) begin
         row_ff       <= cmd.row[IDX_W-1:0];
         cur_dist_ff  <= tbl_dist;
         cur_reach_ff <= tbl_reach;
      end else if (relax && !s1_check_ff && (s1_col_ff == row_ff)) begin
         cur_dist_ff <= sum;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_status) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.vertex      <= cmd.vertex;
         rsp_ff.distance    <= tbl_reach ? tbl_dist : INT_MAX;
         rsp_ff.reachable   <= tbl_reach;
         rsp_ff.status      <= STATUS_OK;
         rsp_ff.last_result <= cmd.last_result;
      end else if (cmd.emit_status) begin
         rsp_ff.vertex      <= '0;
         rsp_ff.distance    <= '0;
         rsp_ff.reachable   <= 1'b0;
         rsp_ff.status      <= cmd.status;
         rsp_ff.last_result <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.found    = found_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // the table read port is never claimed twice
   a_read_port: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(cmd.load_row || cmd.emit || cmd.emit_status))
      else $error("distance table read port conflict");

   // relaxation passes never raise the negative cycle flag
   a_found_check: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_check_ff) |=> (found_ff == $past(found_ff)))
      else $error("cycle flag changed outside checking pass");

   // a run starts with only the source reachable
   a_init_reach: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> ($countones(reach_ff) == 1))
      else $error("reachable set wrong after run start");

endmodule

>>> rtl/bellman_ford_shortest_paths.sv
// top level of the single source shortest path block
// depends on bfsp_pkg, bfsp_ctrl, bfsp_datapath (and bfsp_ram below it)
`timescale 1ns / 1ps

// Edge entries are loaded one per cycle while idle into a weight matrix (zero weight is
// no edge). The entry marked last starts a run from source_node over node_count
// vertices (n, saturated to the matrix size). The run makes n-1 relaxation passes and
// one checking pass; each pass sweeps n rows of n columns through the one read port of
// the matrix memory, and each row first loads the row's distance from the table. Then
// n results follow at one per cycle when the consumer keeps up. A bad source or a
// negative cycle gives one status result instead. No new entry is taken until the last
// result of a run has been placed in the output register.
module bellman_ford_shortest_paths #(
   parameter int MAX_NODES = bfsp_pkg::MAX_NODES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bfsp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bfsp_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfsp_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import bfsp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   bfsp_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_last    (req_data.last_entry),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // storage and arithmetic
   bfsp_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

endmodule
